/* rtl/core/rotation_matrix_to_quaternion_defines.svh */
// Assertion macros for the rotation matrix to quaternion block.
// Included by the RTL files that carry concurrent assertions.
`ifndef ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`ifndef SYNTHESIS
`define RMQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define RMQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define RMQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RMQ_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/rmq_pkg.sv */
// Shared types, constants and width helpers for the rotation matrix to quaternion block.
// No dependencies.
package rmq_pkg;
	localparam int DATA_W = 16;
	localparam int MAG_W = 17;
	localparam int FRAC_BITS_DEF = 14;
	localparam int QDEPTH = 4;
	localparam int LANES = 3;

	typedef enum logic [1:0] {
		BR_W = 2'd0,
		BR_X = 2'd1,
		BR_Y = 2'd2,
		BR_Z = 2'd3
	} branch_t;

	typedef struct packed {
		branch_t branch;
		logic bad;
		logic [LANES-1:0] neg;
	} rmq_ctl_t;

	function automatic int rad_width(input int frac);
		return ((frac > MAG_W) ? frac : MAG_W) + 2;
	endfunction
endpackage

/* rtl/core/rmq_if.sv */
// Valid/ready channel interfaces for matrix input and quaternion output.
// Depends on nothing.
interface rmq_mat_if;
	logic valid;
	logic ready;
	logic signed [15:0] m11, m12, m13, m21, m22, m23, m31, m32, m33;
	modport source(output valid, m11, m12, m13, m21, m22, m23, m31, m32, m33, input ready);
	modport sink(input valid, m11, m12, m13, m21, m22, m23, m31, m32, m33, output ready);
endinterface

interface rmq_quat_if;
	logic valid;
	logic ready;
	logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
	logic bad_input;
	modport source(output valid, quat_w, quat_x, quat_y, quat_z, bad_input, input ready);
	modport sink(input valid, quat_w, quat_x, quat_y, quat_z, bad_input, output ready);
endinterface

/* rtl/core/rmq_front.sv */
// Front end: picks the branch, forms the radicand and the three numerators.
// Depends on rmq_pkg and rmq_mat_if.
module rmq_front #(
	parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
	rmq_mat_if.sink mat,
	input logic full,
	output logic push,
	output rmq_pkg::rmq_ctl_t ctl,
	output logic [rmq_pkg::rad_width(FRAC_BITS)-1:0] rad,
	output logic [rmq_pkg::MAG_W-1:0] mag [rmq_pkg::LANES]
);
	import rmq_pkg::*;

	localparam int RAD_W = rad_width(FRAC_BITS);
	localparam logic signed [RAD_W:0] ONE = (RAD_W+1)'(1) << FRAC_BITS;

	logic signed [17:0] trace;
	logic signed [RAD_W:0] rad_s;
	logic signed [MAG_W-1:0] num [LANES];
	branch_t br;

	assign mat.ready = !full;
	assign push = mat.valid && !full;
	assign trace = 18'(mat.m11) + 18'(mat.m22) + 18'(mat.m33);

	always_comb begin
		if (trace > 18'sd0) begin
			br = BR_W;
			rad_s = (RAD_W+1)'(trace) + ONE;
		end else if (mat.m11 > mat.m22 && mat.m11 > mat.m33) begin
			br = BR_X;
			rad_s = ONE + (RAD_W+1)'(mat.m11) - (RAD_W+1)'(mat.m22) - (RAD_W+1)'(mat.m33);
		end else if (mat.m22 > mat.m33) begin
			br = BR_Y;
			rad_s = ONE + (RAD_W+1)'(mat.m22) - (RAD_W+1)'(mat.m11) - (RAD_W+1)'(mat.m33);
		end else begin
			br = BR_Z;
			rad_s = ONE + (RAD_W+1)'(mat.m33) - (RAD_W+1)'(mat.m11) - (RAD_W+1)'(mat.m22);
		end
	end

	always_comb begin
		case (br)
			BR_W: begin
				num[0] = MAG_W'(mat.m32) - MAG_W'(mat.m23);
				num[1] = MAG_W'(mat.m13) - MAG_W'(mat.m31);
				num[2] = MAG_W'(mat.m21) - MAG_W'(mat.m12);
			end
			BR_X: begin
				num[0] = MAG_W'(mat.m32) - MAG_W'(mat.m23);
				num[1] = MAG_W'(mat.m12) + MAG_W'(mat.m21);
				num[2] = MAG_W'(mat.m13) - MAG_W'(mat.m31);
			end
			BR_Y: begin
				num[0] = MAG_W'(mat.m13) - MAG_W'(mat.m31);
				num[1] = MAG_W'(mat.m12) + MAG_W'(mat.m21);
				num[2] = MAG_W'(mat.m23) + MAG_W'(mat.m32);
			end
			default: begin
				num[0] = MAG_W'(mat.m21) - MAG_W'(mat.m12);
				num[1] = MAG_W'(mat.m13) + MAG_W'(mat.m31);
				num[2] = MAG_W'(mat.m23) + MAG_W'(mat.m32);
			end
		endcase
	end

	always_comb begin
		ctl.branch = br;
		ctl.bad = rad_s[RAD_W] || (rad_s == '0);
		for (int j = 0; j < LANES; j++) begin
			ctl.neg[j] = num[j][MAG_W-1];
			mag[j] = num[j][MAG_W-1] ? MAG_W'(-num[j]) : MAG_W'(num[j]);
		end
	end

	assign rad = rad_s[RAD_W-1:0];
endmodule

/* rtl/core/rmq_queue.sv */
// Small FIFO that decouples the front end from the arithmetic back end.
// Depends on nothing but its parameters.
module rmq_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [WIDTH-1:0] wdata,
	output logic full,
	input logic pop,
	output logic valid,
	output logic [WIDTH-1:0] rdata
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full = (cnt_q == CW'(DEPTH));
	assign valid = (cnt_q != '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wdata;
	end
endmodule

/* rtl/core/rmq_back.sv */
// Back end: pipelined square root, three pipelined dividers and the output register.
// Depends on rmq_pkg, rmq_quat_if and the assertion macro header.
`include "rotation_matrix_to_quaternion_defines.svh"
module rmq_back #(
	parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic pop,
	input rmq_pkg::rmq_ctl_t in_ctl,
	input logic [rmq_pkg::rad_width(FRAC_BITS)-1:0] in_rad,
	input logic [rmq_pkg::MAG_W-1:0] in_mag [rmq_pkg::LANES],
	rmq_quat_if.source quat
);
	import rmq_pkg::*;

	localparam int RAD_W = rad_width(FRAC_BITS);
	localparam int ROOT_W = (RAD_W + FRAC_BITS + 1) / 2;
	localparam int SQ_W = 2 * ROOT_W;
	localparam int RM_W = ROOT_W + 2;
	localparam int DV_W = ROOT_W + 1;
	localparam int DW = MAG_W + FRAC_BITS;
	localparam int NS = ROOT_W;
	localparam int ND = DW;

	logic adv;

	logic sq_vld [NS+1];
	rmq_ctl_t sq_ctl [NS+1];
	logic [MAG_W-1:0] sq_mag [NS+1][LANES];
	logic [SQ_W-1:0] sq_n [NS+1];
	logic [RM_W-1:0] sq_rem [NS+1];
	logic [ROOT_W-1:0] sq_root [NS+1];

	logic dv_vld [ND+1];
	rmq_ctl_t dv_ctl [ND+1];
	logic [ROOT_W-2:0] dv_diag [ND+1];
	logic [DV_W-1:0] dv_div [ND+1];
	logic [DW-1:0] dv_dvd [ND+1][LANES];
	logic [DV_W-1:0] dv_rem [ND+1][LANES];
	logic [DW-1:0] dv_quo [ND+1][LANES];

	logic out_vld_q;
	branch_t out_br_q;
	logic bad_q;
	logic signed [DATA_W-1:0] qw_q, qx_q, qy_q, qz_q;

	logic signed [DATA_W-1:0] lane_sat [LANES];
	logic signed [DATA_W-1:0] diag_sat;
	logic signed [DATA_W-1:0] qw_d, qx_d, qy_d, qz_d;

	assign adv = !out_vld_q || quat.ready;
	assign pop = adv && in_valid;

	assign sq_vld[0] = in_valid;
	assign sq_ctl[0] = in_ctl;
	assign sq_n[0] = SQ_W'(in_rad) << FRAC_BITS;
	assign sq_rem[0] = '0;
	assign sq_root[0] = '0;
	for (genvar j = 0; j < LANES; j++) begin : g_sq_in
		assign sq_mag[0][j] = in_mag[j];
	end

	for (genvar k = 1; k <= NS; k++) begin : g_sq
		logic [RM_W+1:0] cat, sub;
		logic ge;
		assign cat = {sq_rem[k-1], sq_n[k-1][SQ_W-1 -: 2]};
		assign sub = {2'b00, sq_root[k-1], 2'b01};
		assign ge = (cat >= sub);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sq_vld[k] <= 1'b0;
			else if (adv)
				sq_vld[k] <= sq_vld[k-1];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_ctl[k] <= sq_ctl[k-1];
				sq_n[k] <= {sq_n[k-1][SQ_W-3:0], 2'b00};
				sq_rem[k] <= ge ? RM_W'(cat - sub) : RM_W'(cat);
				sq_root[k] <= {sq_root[k-1][ROOT_W-2:0], ge};
				for (int j = 0; j < LANES; j++)
					sq_mag[k][j] <= sq_mag[k-1][j];
			end
		end
	end

	assign dv_vld[0] = sq_vld[NS];
	assign dv_ctl[0] = sq_ctl[NS];
	assign dv_diag[0] = sq_root[NS][ROOT_W-1:1];
	assign dv_div[0] = {sq_root[NS], 1'b0};
	for (genvar j = 0; j < LANES; j++) begin : g_dv_in
		assign dv_dvd[0][j] = {sq_mag[NS][j], FRAC_BITS'(0)};
		assign dv_rem[0][j] = '0;
		assign dv_quo[0][j] = '0;
	end

	for (genvar k = 1; k <= ND; k++) begin : g_dv
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_vld[k] <= 1'b0;
			else if (adv)
				dv_vld[k] <= dv_vld[k-1];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_ctl[k] <= dv_ctl[k-1];
				dv_diag[k] <= dv_diag[k-1];
				dv_div[k] <= dv_div[k-1];
			end
		end

		for (genvar j = 0; j < LANES; j++) begin : g_lane
			logic [DV_W:0] cat;
			logic ge;
			assign cat = {dv_rem[k-1][j], dv_dvd[k-1][j][DW-1]};
			assign ge = (cat >= {1'b0, dv_div[k-1]});

			always_ff @(posedge clk) begin
				if (adv) begin
					dv_dvd[k][j] <= {dv_dvd[k-1][j][DW-2:0], 1'b0};
					dv_rem[k][j] <= ge ? DV_W'(cat - {1'b0, dv_div[k-1]}) : DV_W'(cat);
					dv_quo[k][j] <= {dv_quo[k-1][j][DW-2:0], ge};
				end
			end
		end
	end

	always_comb begin
		for (int j = 0; j < LANES; j++) begin
			if (dv_ctl[ND].neg[j])
				lane_sat[j] = (dv_quo[ND][j] >= DW'(32768)) ? 16'sh8000
					: DATA_W'(DW'(0) - dv_quo[ND][j]);
			else
				lane_sat[j] = (dv_quo[ND][j] > DW'(32767)) ? 16'sh7fff
					: DATA_W'(dv_quo[ND][j]);
		end
		diag_sat = (DW'(dv_diag[ND]) > DW'(32767)) ? 16'sh7fff : DATA_W'(dv_diag[ND]);
	end

	always_comb begin
		case (dv_ctl[ND].branch)
			BR_W: begin
				qw_d = diag_sat;
				qx_d = lane_sat[0];
				qy_d = lane_sat[1];
				qz_d = lane_sat[2];
			end
			BR_X: begin
				qw_d = lane_sat[0];
				qx_d = diag_sat;
				qy_d = lane_sat[1];
				qz_d = lane_sat[2];
			end
			BR_Y: begin
				qw_d = lane_sat[0];
				qx_d = lane_sat[1];
				qy_d = diag_sat;
				qz_d = lane_sat[2];
			end
			default: begin
				qw_d = lane_sat[0];
				qx_d = lane_sat[1];
				qy_d = lane_sat[2];
				qz_d = diag_sat;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (adv)
			out_vld_q <= dv_vld[ND];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_br_q <= dv_ctl[ND].branch;
			bad_q <= dv_ctl[ND].bad;
			qw_q <= dv_ctl[ND].bad ? '0 : qw_d;
			qx_q <= dv_ctl[ND].bad ? '0 : qx_d;
			qy_q <= dv_ctl[ND].bad ? '0 : qy_d;
			qz_q <= dv_ctl[ND].bad ? '0 : qz_d;
		end
	end

	assign quat.valid = out_vld_q;
	assign quat.quat_w = qw_q;
	assign quat.quat_x = qx_q;
	assign quat.quat_y = qy_q;
	assign quat.quat_z = qz_q;
	assign quat.bad_input = bad_q;

	`RMQ_ASSERT_IMP(a_bad_zero, clk, arst_n, out_vld_q && bad_q, qw_q == 0 && qx_q == 0 && qy_q == 0 && qz_q == 0)
	`RMQ_ASSERT_NXT(a_stall_holds, clk, arst_n, !adv, $stable(dv_vld[ND]))
	`RMQ_ASSERT_IMP(a_diag_sign, clk, arst_n, out_vld_q && !bad_q && out_br_q == BR_W, !qw_q[DATA_W-1])
endmodule

/* rtl/core/rotation_matrix_to_quaternion.sv */
// Top level of the rotation matrix to quaternion converter.
// Depends on rmq_pkg, the channel interfaces, rmq_front, rmq_queue and rmq_back.
// Accepts one 3x3 matrix per clock and returns one quaternion per clock while the output
// is ready. A result passes through the queue, the square root pipeline, the divider pipeline and
// the output register; ROOT_W = (max(FRAC_BITS, 17) + FRAC_BITS + 3) / 2 is the root width.
// The square root pipeline gives one root bit a stage, and the restoring
// divider pipeline one quotient bit a stage. A four-entry queue between the front end and
// the arithmetic lets the input keep flowing until it fills while the output is stalled.
module rotation_matrix_to_quaternion #(
	parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	rmq_mat_if.sink mat,
	rmq_quat_if.source quat
);
	import rmq_pkg::*;

	localparam int RAD_W = rad_width(FRAC_BITS);
	localparam int CTL_W = $bits(rmq_ctl_t);
	localparam int ENT_W = CTL_W + RAD_W + LANES * MAG_W;

	logic push, full, pop, q_valid;
	rmq_ctl_t f_ctl, b_ctl;
	logic [RAD_W-1:0] f_rad, b_rad;
	logic [MAG_W-1:0] f_mag [LANES];
	logic [MAG_W-1:0] b_mag [LANES];
	logic [ENT_W-1:0] wdata, rdata;

	rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.mat(mat),
		.full(full),
		.push(push),
		.ctl(f_ctl),
		.rad(f_rad),
		.mag(f_mag)
	);

	assign wdata = {f_ctl, f_rad, f_mag[0], f_mag[1], f_mag[2]};

	rmq_queue #(.WIDTH(ENT_W), .DEPTH(QDEPTH)) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata(wdata),
		.full(full),
		.pop(pop),
		.valid(q_valid),
		.rdata(rdata)
	);

	assign b_ctl = rmq_ctl_t'(rdata[ENT_W-1 -: CTL_W]);
	assign b_rad = rdata[LANES*MAG_W +: RAD_W];
	assign b_mag[0] = rdata[2*MAG_W +: MAG_W];
	assign b_mag[1] = rdata[MAG_W +: MAG_W];
	assign b_mag[2] = rdata[0 +: MAG_W];

	rmq_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(q_valid),
		.pop(pop),
		.in_ctl(b_ctl),
		.in_rad(b_rad),
		.in_mag(b_mag),
		.quat(quat)
	);
endmodule
